>>> hdl/cgl_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package cgl_pkg;

  localparam int PosW   = 16;
  localparam int ColW   = 32;
  localparam int ByteW  = 8;
  localparam int IdxInW = 4;
  localparam int CntInW = 5;
  localparam int ChW    = 2;
  localparam int BitW   = 3;

  localparam logic [ChW-1:0]  ChLast  = 2'd3;
  localparam logic [BitW-1:0] BitLast = 3'd7;

  localparam logic KindLoad  = 1'b0;
  localparam logic KindQuery = 1'b1;

  // commands from the controller to the datapath
  typedef struct packed {
    logic load;
    logic start;
    logic read;
    logic res_rd;
    logic res_edge;
    logic res_none;
    logic advance;
    logic blend_init;
    logic prep;
    logic div_step;
    logic out_load;
  } cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic n_zero;
    logic eq;
    logic gt;
    logic last;
    logic have_prev;
    logic disc;
    logic bit_last;
    logic ch_last;
    logic out_free;
  } status_t;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_READ = 6'b000010,
    S_CMP  = 6'b000100,
    S_PREP = 6'b001000,
    S_DIV  = 6'b010000,
    S_DONE = 6'b100000
  } state_e;

endpackage
`default_nettype wire

>>> hdl/cgl_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module cgl_ctrl (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  wire              in_valid_i,
  input  wire              in_kind_i,
  output logic             in_ready_o,
  input  cgl_pkg::status_t status_i,
  output cgl_pkg::cmd_t    cmd_o
);
  import cgl_pkg::*;

  state_e state_q, state_d;
  logic   accept;

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (in_kind_i == KindLoad) begin
            cmd_o.load = 1'b1;
          end else begin
            cmd_o.start = 1'b1;
            if (status_i.n_zero) begin
              cmd_o.res_none = 1'b1;
              state_d        = S_DONE;
            end else begin
              state_d = S_READ;
            end
          end
        end
      end
      S_READ: begin
        cmd_o.read = 1'b1;
        state_d    = S_CMP;
      end
      S_CMP: begin
        if (status_i.eq) begin
          cmd_o.res_rd = 1'b1;
          state_d      = S_DONE;
        end else if (status_i.gt) begin
          if (!status_i.have_prev || status_i.disc) begin
            cmd_o.res_edge = 1'b1;
            state_d        = S_DONE;
          end else begin
            cmd_o.blend_init = 1'b1;
            state_d          = S_PREP;
          end
        end else begin
          cmd_o.advance = 1'b1;
          if (status_i.last) begin
            // ran past every stop: last stop colour
            cmd_o.res_rd = 1'b1;
            state_d      = S_DONE;
          end else begin
            state_d = S_READ;
          end
        end
      end
      S_PREP: begin
        cmd_o.prep = 1'b1;
        state_d    = S_DIV;
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (status_i.bit_last) begin
          state_d = status_i.ch_last ? S_DONE : S_PREP;
        end
      end
      S_DONE: begin
        if (status_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule
`default_nettype wire

>>> hdl/cgl_dpath.sv
`timescale 1ns / 1ps
`default_nettype none
module cgl_dpath #(
  parameter int NUM_STOPS = 16
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  cgl_pkg::cmd_t                cmd_i,
  output cgl_pkg::status_t             status_o,
  input  wire [cgl_pkg::IdxInW-1:0]    stop_index_i,
  input  wire [cgl_pkg::PosW-1:0]      position_i,
  input  wire [cgl_pkg::ColW-1:0]      stop_color_i,
  input  wire                          discrete_i,
  input  wire                          cfg_we_i,
  input  wire [cgl_pkg::CntInW-1:0]    cfg_wdata_i,
  input  wire                          out_ready_i,
  output logic                         out_valid_o,
  output logic [cgl_pkg::ColW-1:0]     color_o,
  output logic                         valid_res_o
);
  import cgl_pkg::*;

  localparam int IdxW  = $clog2(NUM_STOPS);
  localparam int NcW   = $clog2(NUM_STOPS + 1);
  localparam int NW    = (NcW > CntInW) ? NcW : CntInW;

  logic [PosW-1:0] pos_mem [NUM_STOPS];
  logic [ColW-1:0] col_mem [NUM_STOPS];

  logic [CntInW-1:0] stop_count_q;
  logic [NW-1:0]     count_ext, n_use;
  logic [IdxW-1:0]   i_q;
  logic              have_prev_q;
  logic [ChW-1:0]    ch_q;
  logic [BitW-1:0]   bit_q;
  logic              out_valid_q;

  logic [PosW-1:0]   pos_q, rd_pos_q, prev_pos_q, den_q, num_q, r_q;
  logic [ColW-1:0]   rd_col_q, prev_col_q, col_lo_q, col_hi_q, res_q, out_color_q;
  logic              disc_q, res_valid_q, out_vres_q;
  logic [ByteW-1:0]  lo_q;

  logic              wr_ok;
  logic [IdxW-1:0]   waddr;
  logic [PosW-1:0]   wdiff;
  logic [23:0]       prod_a, prod_b, dividend;
  logic [PosW:0]     r_ext, r_diff;
  logic              ge;
  logic              out_free;

  assign count_ext = NW'(stop_count_q);
  assign n_use     = (count_ext > NW'(NUM_STOPS)) ? NW'(NUM_STOPS) : count_ext;
  assign wr_ok     = (32'(stop_index_i) < NUM_STOPS);
  assign waddr     = IdxW'(stop_index_i);
  assign out_free  = !out_valid_q || out_ready_i;

  // blend numerator for the top byte of each colour register
  assign wdiff    = den_q - num_q;
  assign prod_a   = 24'(col_lo_q[ColW-1 -: ByteW]) * 24'(wdiff);
  assign prod_b   = 24'(col_hi_q[ColW-1 -: ByteW]) * 24'(num_q);
  assign dividend = prod_a + prod_b;

  // one restoring step, quotient bits shift into lo_q
  assign r_ext  = {r_q, lo_q[ByteW-1]};
  assign ge     = (r_ext >= {1'b0, den_q});
  assign r_diff = r_ext - {1'b0, den_q};

  assign status_o.n_zero    = (n_use == '0);
  assign status_o.eq        = (rd_pos_q == pos_q);
  assign status_o.gt        = (rd_pos_q > pos_q);
  assign status_o.last      = ((NW'(i_q) + NW'(1)) == n_use);
  assign status_o.have_prev = have_prev_q;
  assign status_o.disc      = disc_q;
  assign status_o.bit_last  = (bit_q == BitLast);
  assign status_o.ch_last   = (ch_q == ChLast);
  assign status_o.out_free  = out_free;

  assign out_valid_o = out_valid_q;
  assign color_o     = out_color_q;
  assign valid_res_o = out_vres_q;

  // stop table
  always_ff @(posedge clk_i) begin
    if (cmd_i.load && wr_ok) begin
      pos_mem[waddr] <= position_i;
      col_mem[waddr] <= stop_color_i;
    end
    if (cmd_i.read) begin
      rd_pos_q <= pos_mem[i_q];
      rd_col_q <= col_mem[i_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stop_count_q <= '0;
      i_q          <= '0;
      have_prev_q  <= 1'b0;
      ch_q         <= '0;
      bit_q        <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        stop_count_q <= cfg_wdata_i;
      end
      if (cmd_i.start) begin
        i_q         <= '0;
        have_prev_q <= 1'b0;
      end else if (cmd_i.advance) begin
        i_q         <= i_q + IdxW'(1);
        have_prev_q <= 1'b1;
      end
      if (cmd_i.blend_init) begin
        ch_q  <= '0;
        bit_q <= '0;
      end else if (cmd_i.div_step) begin
        bit_q <= bit_q + BitW'(1);
        if (bit_q == BitLast) begin
          ch_q <= ch_q + ChW'(1);
        end
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      pos_q  <= position_i;
      disc_q <= discrete_i;
    end
    if (cmd_i.advance) begin
      prev_pos_q <= rd_pos_q;
      prev_col_q <= rd_col_q;
    end
    if (cmd_i.res_none) begin
      res_q       <= '0;
      res_valid_q <= 1'b0;
    end else if (cmd_i.res_rd) begin
      res_q       <= rd_col_q;
      res_valid_q <= 1'b1;
    end else if (cmd_i.res_edge) begin
      res_q       <= have_prev_q ? prev_col_q : rd_col_q;
      res_valid_q <= 1'b1;
    end else if (cmd_i.blend_init) begin
      res_valid_q <= 1'b1;
    end else if (cmd_i.div_step && (bit_q == BitLast)) begin
      res_q <= {res_q[ColW-ByteW-1:0], lo_q[ByteW-2:0], ge};
    end
    if (cmd_i.blend_init) begin
      den_q    <= rd_pos_q - prev_pos_q;
      num_q    <= pos_q - prev_pos_q;
      col_lo_q <= prev_col_q;
      col_hi_q <= rd_col_q;
    end else if (cmd_i.prep) begin
      // quotient fits a byte, so the upper part is already below den
      r_q      <= dividend[23:ByteW];
      lo_q     <= dividend[ByteW-1:0];
      col_lo_q <= {col_lo_q[ColW-ByteW-1:0], {ByteW{1'b0}}};
      col_hi_q <= {col_hi_q[ColW-ByteW-1:0], {ByteW{1'b0}}};
    end else if (cmd_i.div_step) begin
      r_q  <= ge ? r_diff[PosW-1:0] : r_ext[PosW-1:0];
      lo_q <= {lo_q[ByteW-2:0], ge};
    end
    if (cmd_i.out_load) begin
      out_color_q <= res_q;
      out_vres_q  <= res_valid_q;
    end
  end

endmodule
`default_nettype wire

>>> hdl/color_gradient_lookup.sv
`timescale 1ns / 1ps
`default_nettype none
// Piecewise linear colour gradient lookup. Load transactions (tuser = 0) write one
// stop (position, RGBA colour) into a slot of the stop table; stops must be loaded
// in ascending position. A query transaction (tuser = 1) scans at most the first
// stop_count slots, capped at NUM_STOPS, and returns one result: the exact stop
// colour, the first or last colour outside the range, the lower colour in discrete
// mode, or a per channel blend floor((c1*(den-num)+c2*num)/den); tuser of the result
// is 0 and the colour 0 when no stops are in use. A query holds the block from its
// transaction to the next one while it scans k stops (one table read and one compare
// per stop) and, when it blends, while one shared bit-serial divider runs a prepare
// step and one step per quotient bit for each of the four channels. A finished
// result waits in the output register while the next transaction is taken.
module color_gradient_lookup #(
  parameter int NUM_STOPS = 16
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  // stop_index[3:0], position[19:4], stop_color[51:20], discrete[52], zero[55:53]
  input  wire  [55:0] s_axis_tdata,
  // kind[0]
  input  wire         s_axis_tuser,
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  // color[31:0]
  output logic [31:0] m_axis_tdata,
  // valid_res[0]
  output logic        m_axis_tuser,
  input  wire         cfg_we_i,
  input  wire  [4:0]  cfg_wdata_i
);
  import cgl_pkg::*;

  cmd_t    cmd;
  status_t status;

  cgl_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_kind_i  (s_axis_tuser),
    .in_ready_o (s_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  cgl_dpath #(
    .NUM_STOPS (NUM_STOPS)
  ) u_dpath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .status_o     (status),
    .stop_index_i (s_axis_tdata[3:0]),
    .position_i   (s_axis_tdata[19:4]),
    .stop_color_i (s_axis_tdata[51:20]),
    .discrete_i   (s_axis_tdata[52]),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .out_ready_i  (m_axis_tready),
    .out_valid_o  (m_axis_tvalid),
    .color_o      (m_axis_tdata),
    .valid_res_o  (m_axis_tuser)
  );

endmodule
`default_nettype wire
